[src/tbmmm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tbmmm_pkg
// shared types and constants of the time-bin min/mean/max decimator
// ----------------------------------------------------------------------------
package tbmmm_pkg;

	localparam int unsigned StampWidth = 32;
	localparam int unsigned ValueWidth = 16;
	localparam int unsigned CountWidth = 16;
	localparam int unsigned SumWidth   = 32;

	// input transaction: stamp, value
	localparam int unsigned InDataWidth  = 48;
	// output transaction: mid stamp, minimum, average, maximum, samples
	localparam int unsigned OutDataWidth = 96;

	typedef logic [StampWidth-1:0]        stamp_t;
	typedef logic signed [ValueWidth-1:0] value_t;
	typedef logic [CountWidth-1:0]        count_t;
	typedef logic signed [SumWidth-1:0]   sum_t;

	localparam count_t MAX_BIN_SAMPLES  = 16'hFFFF;
	localparam stamp_t BIN_LENGTH_RESET = 32'd1000;
	localparam value_t VALUE_MAX        = 16'sh7FFF;
	localparam value_t VALUE_MIN        = -16'sh8000;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

endpackage
`default_nettype wire

[src/time_bin_min_mean_max_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// time_bin_min_mean_max_unit
// decimates timestamped samples into fixed-length bins of min, mean and max
// ----------------------------------------------------------------------------
// Each sample transaction is taken in, then checked against the open bin
// in the cycle after. A sample that does not close a bin is folded into the
// running minimum, maximum, sum and count, and the unit is ready again once
// the evaluate state returns to idle. A sample whose elapsed time from the bin
// start is strictly greater than bin_length closes the bin: the bin's figures
// are set aside, the sample opens the next bin, and a restoring divider works
// out sum / count one quotient bit per cycle, so such a sample occupies the
// unit through accept, evaluate, 32 divide steps and emit, and emit waits as
// long as the previous record still sits in the output register. The record
// sits in an output register, so the next sample is taken while it waits to
// be read. bin_length is written through the cfg channel, which is always
// ready and is meant to be written only while the unit is idle.
module time_bin_min_mean_max_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration write channel
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [tbmmm_pkg::StampWidth-1:0]     cfg_data,     // bin_length
	// sample stream
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// s_tdata: sample_stamp[31:0], sample_value[47:32]
	input  wire logic [tbmmm_pkg::InDataWidth-1:0]    s_tdata,
	// record stream
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// m_tdata: bin_mid_stamp[31:0], bin_minimum[47:32], bin_average[63:48],
	// bin_maximum[79:64], bin_samples[95:80]
	output logic [tbmmm_pkg::OutDataWidth-1:0]        m_tdata
);

	// control
	logic [1:0]                 state_q;
	logic [4:0]                 step_q;
	logic                       bin_open_q;
	logic                       m_tvalid_q;

	// configuration
	tbmmm_pkg::stamp_t          bin_length_q;

	// captured sample
	tbmmm_pkg::stamp_t          stamp_q;
	tbmmm_pkg::value_t          value_q;

	// open bin accumulator
	tbmmm_pkg::stamp_t          start_q;
	tbmmm_pkg::value_t          min_q;
	tbmmm_pkg::value_t          max_q;
	tbmmm_pkg::sum_t            sum_q;
	tbmmm_pkg::count_t          cnt_q;

	// closed bin waiting for its average
	tbmmm_pkg::stamp_t          pend_mid_q;
	tbmmm_pkg::value_t          pend_min_q;
	tbmmm_pkg::value_t          pend_max_q;
	tbmmm_pkg::count_t          pend_cnt_q;

	// divider: magnitude of sum over count, one bit per step
	logic [tbmmm_pkg::CountWidth-1:0] rem_q;
	logic [tbmmm_pkg::SumWidth-1:0]   quo_q;
	tbmmm_pkg::count_t                divisor_q;
	logic                             neg_q;

	logic [tbmmm_pkg::OutDataWidth-1:0] m_tdata_q;

	// evaluation of the captured sample
	tbmmm_pkg::stamp_t          eff_start;
	tbmmm_pkg::stamp_t          elapsed;
	logic                       close_bin;
	tbmmm_pkg::value_t          base_min;
	tbmmm_pkg::value_t          base_max;
	tbmmm_pkg::sum_t            base_sum;
	tbmmm_pkg::count_t          base_cnt;
	tbmmm_pkg::value_t          next_min;
	tbmmm_pkg::value_t          next_max;
	tbmmm_pkg::sum_t            next_sum;
	tbmmm_pkg::count_t          next_cnt;
	logic [tbmmm_pkg::SumWidth-1:0] sum_mag;

	// divider step
	logic [tbmmm_pkg::CountWidth:0]   shifted;
	logic [tbmmm_pkg::CountWidth+1:0] trial;
	logic                             trial_ok;

	// emit
	logic                       out_free;
	tbmmm_pkg::value_t          avg;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == tbmmm_pkg::ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// first sample after reset opens the bin at its own stamp
	assign eff_start = bin_open_q ? start_q : stamp_q;
	assign elapsed   = stamp_q - eff_start;
	assign close_bin = (elapsed > bin_length_q);

	// closing restarts the accumulator before the sample is added
	assign base_min = close_bin ? tbmmm_pkg::VALUE_MAX : min_q;
	assign base_max = close_bin ? tbmmm_pkg::VALUE_MIN : max_q;
	assign base_sum = close_bin ? '0 : sum_q;
	assign base_cnt = close_bin ? '0 : cnt_q;

	always_comb begin
		next_min = (value_q < base_min) ? value_q : base_min;
		next_max = (value_q > base_max) ? value_q : base_max;
		next_sum = base_sum;
		next_cnt = base_cnt;
		// saturated count: only min and max keep moving
		if (base_cnt != tbmmm_pkg::MAX_BIN_SAMPLES) begin
			next_sum = base_sum + tbmmm_pkg::sum_t'(value_q);
			next_cnt = base_cnt + 1'b1;
		end
	end

	assign sum_mag = sum_q[tbmmm_pkg::SumWidth-1] ? (~sum_q + 1'b1) : sum_q;

	// restoring division step
	assign shifted  = {rem_q, quo_q[tbmmm_pkg::SumWidth-1]};
	assign trial    = {1'b0, shifted} - {2'b00, divisor_q};
	assign trial_ok = ~trial[tbmmm_pkg::CountWidth+1];

	// quotient magnitude is at most 32768, so the low bits carry the average
	assign avg = neg_q ? tbmmm_pkg::value_t'(~quo_q[tbmmm_pkg::ValueWidth-1:0] + 1'b1)
	                   : tbmmm_pkg::value_t'(quo_q[tbmmm_pkg::ValueWidth-1:0]);
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tbmmm_pkg::ST_IDLE;
			step_q       <= '0;
			bin_open_q   <= 1'b0;
			m_tvalid_q   <= 1'b0;
			bin_length_q <= tbmmm_pkg::BIN_LENGTH_RESET;
			start_q      <= '0;
			min_q        <= tbmmm_pkg::VALUE_MAX;
			max_q        <= tbmmm_pkg::VALUE_MIN;
			sum_q        <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg_valid) begin
				bin_length_q <= cfg_data;
			end

			// record raised from emit, dropped once taken downstream
			if (state_q == tbmmm_pkg::ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				tbmmm_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= tbmmm_pkg::ST_EVAL;
					end
				end
				tbmmm_pkg::ST_EVAL: begin
					bin_open_q <= 1'b1;
					min_q      <= next_min;
					max_q      <= next_max;
					sum_q      <= next_sum;
					cnt_q      <= next_cnt;
					if (close_bin) begin
						start_q <= stamp_q;
						step_q  <= '0;
						state_q <= tbmmm_pkg::ST_DIV;
					end else begin
						start_q <= eff_start;
						state_q <= tbmmm_pkg::ST_IDLE;
					end
				end
				tbmmm_pkg::ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'd31) begin
						state_q <= tbmmm_pkg::ST_EMIT;
					end
				end
				tbmmm_pkg::ST_EMIT: begin
					if (out_free) begin
						state_q <= tbmmm_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tbmmm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			stamp_q <= s_tdata[tbmmm_pkg::StampWidth-1:0];
			value_q <= tbmmm_pkg::value_t'(s_tdata[tbmmm_pkg::InDataWidth-1:tbmmm_pkg::StampWidth]);
		end

		// set the closed bin aside and load the divider
		if (state_q == tbmmm_pkg::ST_EVAL && close_bin) begin
			pend_mid_q <= start_q + (bin_length_q >> 1);
			pend_min_q <= min_q;
			pend_max_q <= max_q;
			pend_cnt_q <= cnt_q;
			divisor_q  <= cnt_q;
			neg_q      <= sum_q[tbmmm_pkg::SumWidth-1];
			quo_q      <= sum_mag;
			rem_q      <= '0;
		end

		if (state_q == tbmmm_pkg::ST_DIV) begin
			rem_q <= trial_ok ? trial[tbmmm_pkg::CountWidth-1:0]
			                  : shifted[tbmmm_pkg::CountWidth-1:0];
			quo_q <= {quo_q[tbmmm_pkg::SumWidth-2:0], trial_ok};
		end

		if (state_q == tbmmm_pkg::ST_EMIT && out_free) begin
			m_tdata_q <= {pend_cnt_q, pend_max_q, avg, pend_min_q, pend_mid_q};
		end
	end

endmodule
`default_nettype wire
